// ===== src/tvsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvsg_pkg: shared types and constants of the three voice sound generator
// Volume table, register numbers, sequencer states and the generator names.
// ----------------------------------------------------------------------------
package tvsg_pkg;

	localparam int unsigned MAX_TSTATES_DEF = 1023;
	localparam int unsigned TICK_W = 10;
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned CNT_W = 26;
	localparam int unsigned NOISE_W = 17;

	localparam logic [3:0] REG_NOISE_PER = 4'd6;
	localparam logic [3:0] REG_MIXER     = 4'd7;
	localparam logic [3:0] REG_ENV_LO    = 4'd11;
	localparam logic [3:0] REG_ENV_HI    = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

	localparam logic [11:0] MIX_OFFSET = 12'd512;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SUB,
		ST_MIX,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		GEN_TONE_A,
		GEN_TONE_B,
		GEN_TONE_C,
		GEN_NOISE
	} gen_t;

	function automatic logic [9:0] vol_lookup(input logic [3:0] v);
		logic [9:0] r;
		case (v)
			4'd0:  r = 10'd0;
			4'd1:  r = 10'd9;
			4'd2:  r = 10'd14;
			4'd3:  r = 10'd20;
			4'd4:  r = 10'd29;
			4'd5:  r = 10'd42;
			4'd6:  r = 10'd58;
			4'd7:  r = 10'd93;
			4'd8:  r = 10'd115;
			4'd9:  r = 10'd181;
			4'd10: r = 10'd241;
			4'd11: r = 10'd307;
			4'd12: r = 10'd389;
			4'd13: r = 10'd469;
			4'd14: r = 10'd578;
			4'd15: r = 10'd682;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/tvsg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvsg_in_if / tvsg_out_if: valid-ready channels of the sound generator
// Request channel (write or render) and sample channel.
// ----------------------------------------------------------------------------
interface tvsg_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [3:0] reg_index;
	logic [7:0] reg_value;
	logic [9:0] tstates;
	modport source (output valid, req_type, reg_index, reg_value, tstates, input ready);
	modport sink (input valid, req_type, reg_index, reg_value, tstates, output ready);
endinterface

interface tvsg_out_if;
	logic              valid;
	logic              ready;
	logic signed [11:0] sample;
	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface
`default_nettype wire

// ===== src/tvsg_env.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvsg_env: envelope shaper
// Steps the 32-phase envelope once per strobe until held; restart clears phase and hold.
// ----------------------------------------------------------------------------
module tvsg_env (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       restart,
	input  wire logic       step,
	input  wire logic [3:0] shape,
	output logic      [3:0] level
);

	logic [4:0] phase_q;
	logic       held_q;
	logic [3:0] level_q;
	logic [4:0] phase_nx;
	logic       rising;

	assign phase_nx = phase_q + 5'd1;
	assign level = level_q;

	always_comb begin
		rising = shape[2];
		if (shape[3] && shape[1] && phase_nx[4])
			rising = !rising;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			held_q  <= 1'b0;
			level_q <= '0;
		end else if (restart) begin
			phase_q <= '0;
			held_q  <= 1'b0;
		end else if (step && !held_q) begin
			phase_q <= phase_nx;
			if (phase_nx == 5'd0 && !shape[3]) begin
				level_q <= '0;
				held_q  <= 1'b1;
			end else if (phase_nx == 5'd0 && shape[0]) begin
				level_q <= (shape[1] ? shape[2] : !shape[2]) ? 4'hF : 4'h0;
				held_q  <= 1'b1;
			end else begin
				level_q <= rising ? phase_nx[3:0] : 4'hF - phase_nx[3:0];
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) held_q && !restart |=> $stable(level_q))
		else $error("held envelope changed level");
	assert property (@(posedge clk) disable iff (!arst_n) restart |=> phase_q == 5'd0 && !held_q)
		else $error("envelope restart not applied");
	assert property (@(posedge clk) disable iff (!arst_n) $rose(held_q) |-> level_q == 4'h0 || level_q == 4'hF)
		else $error("envelope held at intermediate level");

endmodule
`default_nettype wire

// ===== src/three_voice_sound_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// three_voice_sound_generator_unit: three tone, noise and envelope generator
// Register writes and render requests in, one mono sample per render out.
// ----------------------------------------------------------------------------
// Write: taken while idle, no result, the block stays ready for the next request.
// Render: half the ticks (plus the carried odd tick) are added to every counter,
// then each period subtraction and each move on to the next generator (five
// generators) goes through a single shared subtract/compare unit, the three
// voices are mixed, then the sample waits for ready. A render holds the block
// until its sample is taken. Async reset clears everything but the sample.
module three_voice_sound_generator_unit #(
	parameter int unsigned MAX_TSTATES = tvsg_pkg::MAX_TSTATES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tvsg_in_if.sink   in_ch,
	tvsg_out_if.source out_ch
);

	localparam logic [tvsg_pkg::TICK_W-1:0] TCAP =
		(MAX_TSTATES > 1023) ? 10'd1023 : tvsg_pkg::TICK_W'(MAX_TSTATES);

	tvsg_pkg::state_t state_q, state_nx;

	logic [7:0]                    regs_q [16];
	logic [tvsg_pkg::CNT_W-1:0]    cnt_q [5];
	logic [2:0]                    tone_q;
	logic                          noise_lvl_q;
	logic [tvsg_pkg::NOISE_W-1:0]  shift_q;
	logic                          carry_q;
	logic [2:0]                    sel_q;
	logic [1:0]                    mix_idx_q;
	logic [11:0]                   sum_q;
	logic signed [11:0]            sample_q;

	logic [3:0]  env_level;
	logic        env_step;
	logic        env_restart;
	logic [tvsg_pkg::CNT_W-1:0] step_amt;
	logic [tvsg_pkg::CNT_W-1:0] cur_cnt;
	logic        ge;
	logic [10:0] total;
	logic [9:0]  ticks;
	logic [11:0] per12;
	logic        accept;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == tvsg_pkg::ST_IDLE);
	assign out_ch.valid = (state_q == tvsg_pkg::ST_OUT);
	assign out_ch.sample = sample_q;

	assign ticks = (in_ch.tstates > TCAP) ? TCAP : in_ch.tstates;
	assign total = {10'd0, carry_q} + {1'b0, ticks};

	// Shared unit: pick the step of the selected generator, compare and subtract
	always_comb begin
		per12 = '0;
		step_amt = '0;
		case (sel_q)
			3'd0, 3'd1, 3'd2: begin
				per12 = {regs_q[{1'b0, sel_q[1:0], 1'b1}][3:0],
					regs_q[{1'b0, sel_q[1:0], 1'b0}]};
				if (per12 == 12'd0)
					per12 = 12'd1;
				step_amt = tvsg_pkg::CNT_W'({per12, 3'b000});
			end
			3'd3: begin
				step_amt = (regs_q[tvsg_pkg::REG_NOISE_PER][4:0] == 5'd0) ?
					tvsg_pkg::CNT_W'(16) :
					tvsg_pkg::CNT_W'({regs_q[tvsg_pkg::REG_NOISE_PER][4:0], 4'b0000});
			end
			3'd4: begin
				step_amt = ({regs_q[tvsg_pkg::REG_ENV_HI], regs_q[tvsg_pkg::REG_ENV_LO]} == 16'd0)
					? tvsg_pkg::CNT_W'(256)
					: tvsg_pkg::CNT_W'({regs_q[tvsg_pkg::REG_ENV_HI],
						regs_q[tvsg_pkg::REG_ENV_LO], 8'h00});
			end
			default: step_amt = '0;
		endcase
	end

	assign cur_cnt = cnt_q[sel_q];
	assign ge = (sel_q <= 3'd4) && (cur_cnt >= step_amt);
	assign env_step = (state_q == tvsg_pkg::ST_SUB) && ge && (sel_q == 3'd4);
	assign env_restart = accept && !in_ch.req_type && (in_ch.reg_index == tvsg_pkg::REG_ENV_SHAPE);

	tvsg_env u_env (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (env_restart),
		.step    (env_step),
		.shape   (regs_q[tvsg_pkg::REG_ENV_SHAPE][3:0]),
		.level   (env_level)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tvsg_pkg::ST_IDLE: if (accept && in_ch.req_type) state_nx = tvsg_pkg::ST_ADD;
			tvsg_pkg::ST_ADD:  state_nx = tvsg_pkg::ST_SUB;
			tvsg_pkg::ST_SUB:  if (!ge && sel_q == 3'd4) state_nx = tvsg_pkg::ST_MIX;
			tvsg_pkg::ST_MIX:  if (mix_idx_q == 2'd2) state_nx = tvsg_pkg::ST_OUT;
			tvsg_pkg::ST_OUT:  if (out_ch.ready) state_nx = tvsg_pkg::ST_IDLE;
			default:           state_nx = tvsg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tvsg_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	logic [10:0] half_q;
	logic        tone_hi;
	logic        noise_en;
	logic        tone_en;
	logic [3:0]  vol;
	logic [7:0]  amp;

	always_comb begin
		tone_en  = !regs_q[tvsg_pkg::REG_MIXER][mix_idx_q];
		noise_en = !regs_q[tvsg_pkg::REG_MIXER][3'(mix_idx_q) + 3'd3];
		tone_hi  = (!tone_en || tone_q[mix_idx_q]) && (!noise_en || noise_lvl_q);
		amp      = regs_q[4'd8 + 4'(mix_idx_q)];
		vol      = amp[4] ? env_level : amp[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				regs_q[i] <= '0;
			for (int i = 0; i < 5; i++)
				cnt_q[i] <= '0;
			tone_q      <= '0;
			noise_lvl_q <= 1'b0;
			shift_q     <= tvsg_pkg::NOISE_W'(1);
			carry_q     <= 1'b0;
			sel_q       <= '0;
			mix_idx_q   <= '0;
			sum_q       <= '0;
			half_q      <= '0;
		end else begin
			case (state_q)
				tvsg_pkg::ST_IDLE: begin
					if (accept && !in_ch.req_type) begin
						regs_q[in_ch.reg_index] <= in_ch.reg_value;
						if (in_ch.reg_index == tvsg_pkg::REG_ENV_SHAPE)
							cnt_q[4] <= '0;
					end else if (accept) begin
						half_q  <= {1'b0, total[10:1]};
						carry_q <= total[0];
					end
				end
				tvsg_pkg::ST_ADD: begin
					for (int i = 0; i < 5; i++)
						cnt_q[i] <= cnt_q[i] + tvsg_pkg::CNT_W'(half_q);
					sel_q <= '0;
				end
				tvsg_pkg::ST_SUB: begin
					if (ge) begin
						cnt_q[sel_q] <= cur_cnt - step_amt;
						if (sel_q < 3'd3)
							tone_q[sel_q[1:0]] <= !tone_q[sel_q[1:0]];
						else if (sel_q == 3'd3) begin
							shift_q     <= {shift_q[0] ^ shift_q[3], shift_q[16:1]};
							noise_lvl_q <= shift_q[1];
						end
					end else begin
						sel_q <= sel_q + 3'd1;
					end
					mix_idx_q <= '0;
					sum_q     <= '0;
				end
				tvsg_pkg::ST_MIX: begin
					if (tone_hi)
						sum_q <= sum_q + {2'b00, tvsg_pkg::vol_lookup(vol)};
					mix_idx_q <= mix_idx_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tvsg_pkg::ST_MIX && mix_idx_q == 2'd2)
			sample_q <= (tone_hi ? sum_q + {2'b00, tvsg_pkg::vol_lookup(vol)} : sum_q)
				- tvsg_pkg::MIX_OFFSET;
	end

	assert property (@(posedge clk) disable iff (!arst_n) shift_q != '0)
		else $error("noise shifter locked at zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tvsg_pkg::ST_SUB && sel_q < 3'd3 && ge |=> tone_q != $past(tone_q))
		else $error("tone subtraction without toggle");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tvsg_pkg::ST_OUT && !out_ch.ready |=> $stable(sample_q))
		else $error("pending sample changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != tvsg_pkg::ST_IDLE |-> !in_ch.ready)
		else $error("request taken while busy");

endmodule
`default_nettype wire

// ===== verif/tvsg_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tvsg_checker: sample predictor and scoreboard for the sound generator
// Watches both channels, models the tone, noise and envelope generators and
// compares every sample with the oldest predicted one.
// ----------------------------------------------------------------------------
module tvsg_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	tvsg_in_if.sink   in_mon,
	tvsg_out_if.sink  out_mon,
	output int        fail_count,
	output int        pending,
	output int        samples_seen,
	output int        writes_seen
);

	logic [7:0]  regs [16];
	logic [31:0] tone_cnt [3];
	logic        tone_lvl [3];
	logic [31:0] noise_cnt;
	logic        noise_lvl;
	logic [16:0] lfsr;
	logic [31:0] env_cnt;
	logic [4:0]  env_phase;
	logic [3:0]  env_lvl;
	logic        env_held;
	logic        carry;
	logic signed [11:0] sample_q [$];

	function automatic int unsigned vol_of(input logic [3:0] v);
		int unsigned tbl [16] = '{0, 9, 14, 20, 29, 42, 58, 93, 115, 181, 241, 307,
			389, 469, 578, 682};
		return tbl[v];
	endfunction

	task automatic step_envelope();
		logic [3:0] shape;
		logic       rising;
		if (env_held) return;
		env_phase = env_phase + 5'd1;
		shape = regs[tvsg_pkg::REG_ENV_SHAPE][3:0];
		if (env_phase == 0) begin
			if (!shape[3]) begin
				env_lvl = 0;
				env_held = 1;
				return;
			end
			if (shape[0]) begin
				env_lvl = (shape[1] ? shape[2] : !shape[2]) ? 4'd15 : 4'd0;
				env_held = 1;
				return;
			end
		end
		rising = shape[2];
		if (shape[3] && shape[1] && env_phase[4]) rising = !rising;
		env_lvl = rising ? env_phase[3:0] : 4'd15 - env_phase[3:0];
	endtask

	task automatic render(input logic [9:0] ticks);
		logic [31:0] total, cyc, per, stp;
		logic        fb, hi;
		int          sum;
		logic [7:0]  amp;
		total = carry + ticks;
		cyc = total >> 1;
		carry = total[0];
		for (int c = 0; c < 3; c++) begin
			per = {regs[2*c+1][3:0], regs[2*c]};
			if (per == 0) per = 1;
			stp = per << 3;
			tone_cnt[c] += cyc;
			while (tone_cnt[c] >= stp) begin
				tone_cnt[c] -= stp;
				tone_lvl[c] = !tone_lvl[c];
			end
		end
		per = regs[tvsg_pkg::REG_NOISE_PER][4:0];
		if (per == 0) per = 1;
		stp = per << 4;
		noise_cnt += cyc;
		while (noise_cnt >= stp) begin
			noise_cnt -= stp;
			fb = lfsr[0] ^ lfsr[3];
			lfsr = {fb, lfsr[16:1]};
			noise_lvl = lfsr[0];
		end
		per = {regs[tvsg_pkg::REG_ENV_HI], regs[tvsg_pkg::REG_ENV_LO]};
		if (per == 0) per = 1;
		stp = per << 8;
		env_cnt += cyc;
		while (env_cnt >= stp) begin
			env_cnt -= stp;
			step_envelope();
		end
		sum = 0;
		for (int c = 0; c < 3; c++) begin
			hi = (regs[tvsg_pkg::REG_MIXER][c] || tone_lvl[c]) &&
				(regs[tvsg_pkg::REG_MIXER][c+3] || noise_lvl);
			if (hi) begin
				amp = regs[8+c];
				sum += vol_of(amp[4] ? env_lvl : amp[3:0]);
			end
		end
		sample_q.push_back(12'(sum - 512));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = 0;
			for (int c = 0; c < 3; c++) begin
				tone_cnt[c] = 0;
				tone_lvl[c] = 0;
			end
			noise_cnt = 0;
			noise_lvl = 0;
			lfsr = 17'd1;
			env_cnt = 0;
			env_phase = 0;
			env_lvl = 0;
			env_held = 0;
			carry = 0;
			sample_q.delete();
			fail_count <= 0;
			pending <= 0;
			samples_seen <= 0;
			writes_seen <= 0;
		end else begin
			// compare before predicting: a render accepted now yields its sample later
			if (out_mon.valid && out_mon.ready) begin
				samples_seen <= samples_seen + 1;
				if (sample_q.size() == 0) begin
					$display("%0t: unexpected sample %0d", $time, out_mon.sample);
					fail_count <= fail_count + 1;
				end else begin
					if (sample_q[0] !== out_mon.sample) begin
						$display("%0t: sample expected %0d actual %0d", $time,
							sample_q[0], out_mon.sample);
						fail_count <= fail_count + 1;
					end
					void'(sample_q.pop_front());
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.req_type) begin
					render(in_mon.tstates);
				end else begin
					writes_seen <= writes_seen + 1;
					regs[in_mon.reg_index] = in_mon.reg_value;
					if (in_mon.reg_index == tvsg_pkg::REG_ENV_SHAPE) begin
						env_phase = 0;
						env_held = 0;
						env_cnt = 0;
					end
				end
			end
			pending <= sample_q.size();
		end
	end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the three voice sound generator
// Directed register writes and renders, then random tunes with random gaps
// on both channels; the checker predicts and compares every sample.
// ----------------------------------------------------------------------------
module testbench;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fail_count, pending, samples_seen, writes_seen;
	int   idle_cycles;
	logic done;

	tvsg_in_if  in_ch ();
	tvsg_out_if out_ch ();

	three_voice_sound_generator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	tvsg_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_mon       (in_ch.sink),
		.out_mon      (out_ch.sink),
		.fail_count   (fail_count),
		.pending      (pending),
		.samples_seen (samples_seen),
		.writes_seen  (writes_seen)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// sink side: random stalls, with calm stretches
	initial begin
		int gap;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				out_ch.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	task automatic send(input logic rt, input logic [3:0] idx, input logic [7:0] val,
		input logic [9:0] ticks, input int gap);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1;
		in_ch.req_type  <= rt;
		in_ch.reg_index <= idx;
		in_ch.reg_value <= val;
		in_ch.tstates   <= ticks;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
		send(1'b0, idx, val, 10'($urandom), $urandom_range(0, 6));
	endtask

	task automatic render_req(input logic [9:0] ticks);
		send(1'b1, 4'($urandom), 8'($urandom), ticks, $urandom_range(0, 6));
	endtask

	// keep periods short mostly so generators actually move
	task automatic random_tune();
		write_reg(4'd0, 8'($urandom_range(0, 40)));
		write_reg(4'd1, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 255) & 8'hF0));
		write_reg(4'd2, 8'($urandom));
		write_reg(4'd3, 8'($urandom) & (($urandom_range(0, 3) == 0) ? 8'hFF : 8'hF0));
		write_reg(4'd4, 8'($urandom_range(0, 20)));
		write_reg(4'd5, 8'($urandom));
		write_reg(tvsg_pkg::REG_NOISE_PER, 8'($urandom));
		write_reg(tvsg_pkg::REG_MIXER, 8'($urandom));
		write_reg(4'd8, 8'($urandom));
		write_reg(4'd9, 8'($urandom));
		write_reg(4'd10, 8'($urandom));
		write_reg(tvsg_pkg::REG_ENV_LO, 8'($urandom_range(0, 3)));
		write_reg(tvsg_pkg::REG_ENV_HI, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0);
		write_reg(tvsg_pkg::REG_ENV_SHAPE, 8'($urandom));
	endtask

	initial begin
		int n;
		bit paused;
		in_ch.valid     = 0;
		in_ch.req_type  = 0;
		in_ch.reg_index = 0;
		in_ch.reg_value = 0;
		in_ch.tstates   = 0;
		paused          = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: zero periods, extremes of ticks, held envelope, unused bits
		render_req(10'd0);
		render_req(10'd1);
		render_req(10'd1023);
		write_reg(tvsg_pkg::REG_MIXER, 8'h00);
		write_reg(4'd8, 8'h1F);
		write_reg(4'd9, 8'hEF);
		write_reg(4'd10, 8'h10);
		write_reg(tvsg_pkg::REG_ENV_SHAPE, 8'h0D);
		render_req(10'd1023);
		render_req(10'd1023);
		write_reg(4'd0, 8'hFF);
		write_reg(4'd1, 8'hFF);
		write_reg(tvsg_pkg::REG_NOISE_PER, 8'hFF);
		write_reg(tvsg_pkg::REG_ENV_LO, 8'hFF);
		write_reg(tvsg_pkg::REG_ENV_HI, 8'hFF);
		render_req(10'd512);
		write_reg(4'd0, 8'h01);
		write_reg(4'd1, 8'h00);
		write_reg(tvsg_pkg::REG_ENV_HI, 8'h00);
		write_reg(tvsg_pkg::REG_ENV_LO, 8'h00);
		write_reg(tvsg_pkg::REG_ENV_SHAPE, 8'h0A);
		render_req(10'd1023);
		write_reg(tvsg_pkg::REG_MIXER, 8'hFF);
		write_reg(4'd14, 8'hA5);
		write_reg(4'd15, 8'h5A);
		render_req(10'd3);
		n = 25;
		while (n < 800) begin
			if ($urandom_range(0, 9) == 0) begin
				random_tune();
				n += 14;
			end else if ($urandom_range(0, 4) == 0) begin
				write_reg(4'($urandom), 8'($urandom));
				n++;
			end else begin
				render_req(($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 60)));
				n++;
			end
			// hold the sender once until every sample is out
			if (!paused && n >= 400) begin
				paused = 1;
				in_ch.valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		in_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		done <= 1;
	end

	initial begin
		done = 0;
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (done) begin
				$display("Covered %0d register writes and %0d samples with random gaps.",
					writes_seen, samples_seen);
				if (fail_count == 0)
					$display("No mismatches found");
				else
					$display("Mismatches found");
				$finish;
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout with %0d samples outstanding", pending);
				$display("Mismatches found");
				$finish;
			end
		end
	end
endmodule
